// ===== design/dpc_pkg.sv =====
// dpc_pkg: shared types and constants for the differential pump controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package dpc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned TempW   = 12;
  localparam int unsigned DeltaW  = 8;
  localparam int unsigned LockW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegMaxPoolTemp   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOnDelta       = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOffDelta      = 2'd2;
  localparam logic [CfgIdxW-1:0] RegLockoutSecond = 2'd3;

  // reset values of the configuration registers
  localparam logic signed [TempW-1:0] MaxPoolTempRst = 12'sd300;
  localparam logic [DeltaW-1:0]       OnDeltaRst     = 8'd14;
  localparam logic [DeltaW-1:0]       OffDeltaRst    = 8'd10;
  localparam logic [LockW-1:0]        LockoutSecRst  = 16'd60;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef struct packed {
    logic [TimeW-1:0]        now_seconds;
    logic signed [TempW-1:0] collector_temp;
    logic signed [TempW-1:0] pool_temp;
    logic signed [TempW-1:0] outlet_temp;
  } dpc_in_t;

  typedef struct packed {
    logic             pump_on;
    logic             started;
    logic             stopped;
    logic             in_lockout;
    logic [TimeW-1:0] start_total;
    logic [TimeW-1:0] run_total_seconds;
    logic [TimeW-1:0] run_elapsed_seconds;
  } dpc_out_t;

  typedef struct packed {
    logic signed [TempW-1:0] max_pool_temp;
    logic [DeltaW-1:0]       on_delta;
    logic [DeltaW-1:0]       off_delta;
    logic [LockW-1:0]        lockout_seconds;
  } dpc_cfg_t;

  typedef struct packed {
    logic             pump_running;
    logic             lockout_active;
    logic [TimeW-1:0] lockout_end;
    logic [TimeW-1:0] run_start;
    logic [TimeW-1:0] start_count;
    logic [TimeW-1:0] run_accumulated;
  } dpc_state_t;

  // 32-bit add that sticks at the top value
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TimeW] ? TimeMax : sum[TimeW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/dpc_cfg_regs.sv =====
// dpc_cfg_regs: configuration register file of the pump controller
// depends on dpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dpc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [dpc_pkg::CfgDatW-1:0]    cfg_data_i,
  output dpc_pkg::dpc_cfg_t                   cfg_o
);
  import dpc_pkg::*;

  dpc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegMaxPoolTemp:   cfg_d.max_pool_temp   = $signed(cfg_data_i[TempW-1:0]);
        RegOnDelta:       cfg_d.on_delta        = cfg_data_i[DeltaW-1:0];
        RegOffDelta:      cfg_d.off_delta       = cfg_data_i[DeltaW-1:0];
        RegLockoutSecond: cfg_d.lockout_seconds = cfg_data_i[LockW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_pool_temp   <= MaxPoolTempRst;
      cfg_q.on_delta        <= OnDeltaRst;
      cfg_q.off_delta       <= OffDeltaRst;
      cfg_q.lockout_seconds <= LockoutSecRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/dpc_eval.sv =====
// dpc_eval: one evaluation tick, next state and result from the current state
// depends on dpc_pkg; purely combinational
`timescale 1ns / 1ps
`default_nettype none

module dpc_eval (
  input  wire dpc_pkg::dpc_in_t    item_i,
  input  wire dpc_pkg::dpc_cfg_t   cfg_i,
  input  wire dpc_pkg::dpc_state_t state_i,
  output dpc_pkg::dpc_state_t      state_o,
  output dpc_pkg::dpc_out_t        result_o
);
  import dpc_pkg::*;

  localparam int unsigned SumW = TempW + 2;

  logic                   lock_hold;
  logic                   evaluate;
  logic                   heat_ok;
  logic                   outlet_low;
  logic                   do_start;
  logic                   do_stop;
  logic                   time_fwd;
  logic [TimeW-1:0]       elapsed;
  logic signed [SumW-1:0] pool_ext;
  logic signed [SumW-1:0] on_lim;
  logic signed [SumW-1:0] off_lim;

  always_comb begin
    lock_hold = state_i.lockout_active && (item_i.now_seconds < state_i.lockout_end);
    evaluate  = !lock_hold;

    pool_ext = SumW'(item_i.pool_temp);
    on_lim   = pool_ext + $signed({{(SumW-DeltaW){1'b0}}, cfg_i.on_delta});
    off_lim  = pool_ext + $signed({{(SumW-DeltaW){1'b0}}, cfg_i.off_delta});

    heat_ok    = (SumW'(item_i.collector_temp) > on_lim) &&
                 (item_i.pool_temp < cfg_i.max_pool_temp);
    outlet_low = SumW'(item_i.outlet_temp) < off_lim;

    do_start = evaluate && heat_ok && !state_i.pump_running;
    do_stop  = evaluate && state_i.pump_running && (!heat_ok || outlet_low);

    // run time counts as zero when time went backwards
    time_fwd = item_i.now_seconds >= state_i.run_start;
    elapsed  = time_fwd ? (item_i.now_seconds - state_i.run_start) : '0;

    state_o = state_i;
    if (evaluate) begin
      state_o.lockout_active = 1'b0;
    end
    if (do_start) begin
      state_o.pump_running = 1'b1;
      state_o.start_count  = sat_add(state_i.start_count, TimeW'(1));
      state_o.run_start    = item_i.now_seconds;
    end
    if (do_stop) begin
      state_o.pump_running    = 1'b0;
      state_o.run_accumulated = sat_add(state_i.run_accumulated, elapsed);
      state_o.lockout_active  = 1'b1;
      state_o.lockout_end     = sat_add(item_i.now_seconds,
                                        {{(TimeW-LockW){1'b0}}, cfg_i.lockout_seconds});
    end

    result_o.pump_on             = state_o.pump_running;
    result_o.started             = do_start;
    result_o.stopped             = do_stop;
    result_o.in_lockout          = state_o.lockout_active;
    result_o.start_total         = state_o.start_count;
    result_o.run_total_seconds   = state_o.run_accumulated;
    // a fresh start has run_start equal to now, so it reports zero
    result_o.run_elapsed_seconds = (state_o.pump_running && !do_start) ? elapsed : '0;
  end

endmodule

`default_nettype wire

// ===== design/differential_pump_controller.sv =====
// differential_pump_controller: solar pool pump controller, top level
// path: a tick is held in the input register, then its result in the result register
// throughput: one transaction per cycle while the result channel does not stall, set by the
// state update between the input register and the result register
// reset: pump off, no lockout, counters zero, registers at their defaults
// depends on dpc_pkg, dpc_cfg_regs and dpc_eval
`timescale 1ns / 1ps
`default_nettype none

module differential_pump_controller (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic [dpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [dpc_pkg::CfgDatW-1:0] cfg_data_i,
  // tick input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire dpc_pkg::dpc_in_t            in_data_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output dpc_pkg::dpc_out_t                out_data_o
);
  import dpc_pkg::*;

  // configuration registers
  dpc_cfg_t   cfg;

  // input register stage
  logic       s1_valid_q, s1_valid_d;
  dpc_in_t    s1_item_q;

  // controller state
  dpc_state_t state_q, state_nxt;

  // result register
  logic       out_valid_q, out_valid_d;
  dpc_out_t   out_data_q;
  dpc_out_t   result;

  logic       in_accept;
  logic       out_free;
  logic       s1_fire;

  dpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dpc_eval u_eval (
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .state_o  (state_nxt),
    .result_o (result)
  );

  // the result register frees up when empty or when its transaction leaves
  assign out_free   = !out_valid_q || !out_stall_i;
  // the held tick moves on and commits its state update
  assign s1_fire    = s1_valid_q && out_free;
  // only stall when the input register holds a tick that cannot move
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_fire);
  assign out_valid_d = s1_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      // state only advances when a tick is committed to the result register
      if (s1_fire) begin
        state_q <= state_nxt;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
    end
    if (s1_fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // a tick never both starts and stops the pump
  a_start_stop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.started && out_data_o.stopped))
    else $error("start and stop on the same tick");

  // a fresh start leaves the pump running with zero elapsed time
  a_start_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.started) |->
      (out_data_o.pump_on && out_data_o.run_elapsed_seconds == '0))
    else $error("start result inconsistent");

  // a lockout only follows a stop, so the pump is off throughout
  a_lockout_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.lockout_active |-> !state_q.pump_running)
    else $error("pump running during lockout");

  // a held tick stays in the input register until it can move on
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("held tick lost");

  // state only moves when a tick is committed
  a_state_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(state_q))
    else $error("state changed without a tick");
`endif

endmodule

`default_nettype wire

// ===== sim/dpc_checker.sv =====
// dpc_checker: result predictor and scoreboard for the differential pump controller
// watches the config port and both handshake channels; depends on dpc_pkg
`timescale 1ns / 1ps

module dpc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dpc_pkg::CfgDatW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  dpc_pkg::dpc_in_t             in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  dpc_pkg::dpc_out_t            out_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import dpc_pkg::*;

  // shadow copy of the configuration registers
  logic signed [TempW-1:0] pool_limit;
  logic [DeltaW-1:0]       start_margin;
  logic [DeltaW-1:0]       stop_margin;
  logic [LockW-1:0]        hold_off;

  // shadow copy of the controller state
  logic             pump_on_q;
  logic             locked_q;
  logic [TimeW-1:0] lock_until;
  logic [TimeW-1:0] run_began;
  logic [TimeW-1:0] starts;
  logic [TimeW-1:0] run_sum;

  dpc_out_t expected_q[$];
  int       mismatch_count = 0;

  initial fail_count_o = 0;
  initial pending_o = 0;

  function automatic logic [TimeW-1:0] clip_add(input logic [TimeW-1:0] a,
                                                input logic [TimeW-1:0] b);
    return (a > TimeMax - b) ? TimeMax : a + b;
  endfunction

  // zero when the clock has gone backwards past the run start
  function automatic logic [TimeW-1:0] run_time(input logic [TimeW-1:0] now);
    return (now >= run_began) ? now - run_began : '0;
  endfunction

  function automatic void halt_pump(input logic [TimeW-1:0] now);
    pump_on_q  = 1'b0;
    run_sum    = clip_add(run_sum, run_time(now));
    locked_q   = 1'b1;
    lock_until = clip_add(now, TimeW'(hold_off));
  endfunction

  function automatic dpc_out_t evaluate_tick(input dpc_in_t tick);
    int       coll;
    int       pool;
    int       outlet;
    logic     go;
    logic     warm;
    logic     was_on;
    dpc_out_t r;
    coll   = tick.collector_temp;
    pool   = tick.pool_temp;
    outlet = tick.outlet_temp;
    go     = 1'b1;
    r      = '0;
    if (locked_q) begin
      if (tick.now_seconds >= lock_until) locked_q = 1'b0;
      else go = 1'b0;
    end
    if (go) begin
      was_on = pump_on_q;
      warm   = (coll > pool + int'(start_margin)) && (pool < int'(pool_limit));
      if (warm) begin
        if (!was_on) begin
          pump_on_q = 1'b1;
          starts    = clip_add(starts, 1);
          run_began = tick.now_seconds;
          r.started = 1'b1;
        end else if (outlet < pool + int'(stop_margin)) begin
          halt_pump(tick.now_seconds);
          r.stopped = 1'b1;
        end
      end else if (was_on) begin
        halt_pump(tick.now_seconds);
        r.stopped = 1'b1;
      end
    end
    r.pump_on             = pump_on_q;
    r.in_lockout          = locked_q;
    r.start_total         = starts;
    r.run_total_seconds   = run_sum;
    r.run_elapsed_seconds = pump_on_q ? run_time(tick.now_seconds) : '0;
    return r;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [TimeW-1:0] got,
                               input logic [TimeW-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dpc_out_t want;
    if (!rst_ni) begin
      pool_limit   = MaxPoolTempRst;
      start_margin = OnDeltaRst;
      stop_margin  = OffDeltaRst;
      hold_off     = LockoutSecRst;
      pump_on_q    = 1'b0;
      locked_q     = 1'b0;
      lock_until   = '0;
      run_began    = '0;
      starts       = '0;
      run_sum      = '0;
      expected_q.delete();
      pending_o    <= 0;
    end else begin
      // compare before predicting, so a stray result never meets a fresh entry
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_q.pop_front();
          compare_field("pump_on", out_data_i.pump_on, want.pump_on);
          compare_field("started", out_data_i.started, want.started);
          compare_field("stopped", out_data_i.stopped, want.stopped);
          compare_field("in_lockout", out_data_i.in_lockout, want.in_lockout);
          compare_field("start_total", out_data_i.start_total, want.start_total);
          compare_field("run_total_seconds", out_data_i.run_total_seconds,
                        want.run_total_seconds);
          compare_field("run_elapsed_seconds", out_data_i.run_elapsed_seconds,
                        want.run_elapsed_seconds);
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(evaluate_tick(in_data_i));
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMaxPoolTemp:   pool_limit   = cfg_data_i[TempW-1:0];
          RegOnDelta:       start_margin = cfg_data_i[DeltaW-1:0];
          RegOffDelta:      stop_margin  = cfg_data_i[DeltaW-1:0];
          RegLockoutSecond: hold_off     = cfg_data_i[LockW-1:0];
          default: ;
        endcase
      end
      pending_o <= expected_q.size();
    end
    fail_count_o <= mismatch_count;
  end

endmodule

// ===== sim/testbench.sv =====
// testbench: top level for the differential pump controller
// drives directed and random tick transactions and config writes; the verdict
// comes from dpc_checker; depends on dpc_pkg and the controller rtl
`timescale 1ns / 1ps

module testbench;
  import dpc_pkg::*;

  // cycles with no transaction on either channel before the run is abandoned
  localparam int unsigned QuietLimit   = 2000;
  // idle cycles after the last result
  localparam int unsigned SettleCycles = 4;
  localparam logic [TempW-1:0] TempLo = 12'h800;
  localparam logic [TempW-1:0] TempHi = 12'h7FF;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDatW-1:0] cfg_data = '0;
  logic               tick_valid = 1'b0;
  logic               tick_stall;
  dpc_in_t            tick_data = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  dpc_out_t           res_data;
  int                 fail_count;
  int                 pending;

  // idling knobs, per phase
  int send_idle_pct = 0;
  int stall_pct = 0;
  int unsigned quiet_cycles = 0;

  // the settings currently programmed, used to aim the random ticks
  logic signed [TempW-1:0] cur_limit = MaxPoolTempRst;
  logic [DeltaW-1:0]       cur_on = OnDeltaRst;
  logic [DeltaW-1:0]       cur_off = OffDeltaRst;
  logic [LockW-1:0]        cur_hold = LockoutSecRst;
  logic [TimeW-1:0]        clock_now = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  differential_pump_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (tick_valid),
    .in_stall_o  (tick_stall),
    .in_data_i   (tick_data),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_data)
  );

  dpc_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (tick_valid),
    .in_stall_i   (tick_stall),
    .in_data_i    (tick_data),
    .out_valid_i  (res_valid),
    .out_stall_i  (res_stall),
    .out_data_i   (res_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side back-pressure
  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog: any accepted transaction on either side counts as progress
  always @(posedge clk) begin
    if ((tick_valid && !tick_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // random gaps first, then hold the tick until the controller takes it
  task automatic send_tick(input dpc_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_data  <= t;
    do @(posedge clk); while (tick_stall);
  endtask

  task automatic feed(input logic [TimeW-1:0] t, input logic [TempW-1:0] coll,
                      input logic [TempW-1:0] pool, input logic [TempW-1:0] outlet);
    dpc_in_t x;
    x.now_seconds    = t;
    x.collector_temp = coll;
    x.pool_temp      = pool;
    x.outlet_temp    = outlet;
    send_tick(x);
  endtask

  // wait for every expected result, then a few quiet cycles
  task automatic settle();
    tick_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // unused upper data bits are filled with noise, the block must ignore them
  task automatic program_regs(input logic [TempW-1:0] lim, input logic [DeltaW-1:0] on,
                              input logic [DeltaW-1:0] off, input logic [LockW-1:0] hold);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= RegMaxPoolTemp;
    cfg_data  <= {4'($urandom), lim};
    @(posedge clk);
    cfg_index <= RegOnDelta;
    cfg_data  <= {8'($urandom), on};
    @(posedge clk);
    cfg_index <= RegOffDelta;
    cfg_data  <= {8'($urandom), off};
    @(posedge clk);
    cfg_index <= RegLockoutSecond;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit = lim;
    cur_on    = on;
    cur_off   = off;
    cur_hold  = hold;
  endtask

  // mostly plausible ticks around the programmed thresholds, with a slowly
  // advancing clock; some jump past a lockout, run backwards or are pure noise
  function automatic dpc_in_t random_tick();
    int      pool;
    int      pick;
    dpc_in_t x;
    pick = $urandom_range(99);
    if (pick < 70) clock_now += $urandom_range(0, 3);
    else if (pick < 90) clock_now += $urandom_range(0, int'(cur_hold) + 2);
    else if (pick < 95) clock_now -= $urandom_range(1, 50);
    else clock_now = $urandom;
    if ($urandom_range(9) == 0) begin
      x.now_seconds    = $urandom;
      x.collector_temp = TempW'($urandom);
      x.pool_temp      = TempW'($urandom);
      x.outlet_temp    = TempW'($urandom);
      return x;
    end
    if ($urandom_range(9) == 0) pool = int'(cur_limit) + int'($urandom_range(0, 10)) - 5;
    else pool = int'($urandom_range(0, 2050)) - 550;
    x.now_seconds    = clock_now;
    x.pool_temp      = TempW'(pool);
    x.collector_temp = TempW'(pool + int'(cur_on) + int'($urandom_range(0, 40)) - 8);
    x.outlet_temp    = TempW'(pool + int'(cur_off) + int'($urandom_range(0, 25)) - 10);
    return x;
  endfunction

  initial begin : stimulus
    logic signed [TempW-1:0] lim;
    logic [DeltaW-1:0]       on;
    logic [DeltaW-1:0]       off;
    logic [LockW-1:0]        hold;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset settings: limit 30.0, margins 1.4 and 1.0, 60 s lockout
    feed(32'd0, TempHi, TempLo, TempLo);           // start at the extremes, low outlet ignored
    feed(32'd5, TempHi, TempLo, TempLo);           // outlet too cold, stop and lock out
    feed(32'd30, TempHi, TempLo, TempHi);          // still locked, nothing moves
    feed(32'd65, 12'd400, 12'd200, 12'd215);       // lockout ends, same tick starts the pump
    feed(32'd70, 12'd400, 12'd200, 12'd210);       // outlet exactly on the stop margin, keeps going
    feed(32'd71, 12'd400, 12'd200, 12'd209);       // one tenth below, stops
    feed(32'd131, 12'd214, 12'd200, 12'd300);      // collector exactly on the start margin
    feed(32'd132, 12'd215, 12'd200, 12'd300);      // one tenth above, starts
    feed(32'd140, 12'd215, 12'd300, 12'd400);      // pool reaches the limit, stops
    feed(32'd200, 12'd600, 12'd299, 12'd400);      // pool just under the limit, starts
    feed(32'd150, 12'd100, 12'd200, 12'd200);      // clock went backwards, run time counts as zero
    feed(32'hFFFF_FFF0, TempHi, TempLo, TempHi);   // start near the top of the clock
    feed(32'hFFFF_FFFF, TempLo, TempHi, TempHi);   // stop, lockout end clips at the top
    feed(32'hFFFF_FFFE, TempHi, TempLo, TempHi);   // locked
    feed(32'hFFFF_FFFF, TempLo, TempHi, TempLo);   // lockout clears, too cold to start

    // lowest limit and widest margins: the pump can never run
    program_regs(TempLo, 8'd255, 8'd255, 16'd0);
    feed(32'd0, TempHi, TempLo, TempHi);

    // highest limit, zero start margin, no lockout: drive the run total into saturation
    program_regs(TempHi, 8'd0, 8'd255, 16'd0);
    feed(32'd0, 12'd1, 12'd0, 12'd254);
    feed(32'hF000_0000, 12'd1, 12'd0, 12'd254);
    feed(32'hF000_0000, 12'd0, 12'd0, 12'd0);
    feed(32'd0, 12'd1, 12'd0, 12'd255);
    feed(32'hF000_0000, 12'd1, 12'd0, 12'd255);
    feed(32'hF000_0000, 12'd0, 12'd0, 12'd0);

    // random part: ten phases, each with its own settings and idling
    for (int phase = 0; phase < 10; phase++) begin
      lim  = TempW'(int'($urandom_range(0, 2050)) - 550);
      on   = DeltaW'($urandom_range(0, 60));
      off  = DeltaW'($urandom_range(0, 40));
      hold = LockW'($urandom_range(0, 12));
      case (phase)
        3: begin
          lim  = TempHi;
          on   = '0;
          off  = '0;
          hold = '0;
        end
        6: begin
          lim  = TempHi;
          on   = 8'd255;
          off  = 8'd255;
          hold = 16'hFFFF;
        end
        8: lim = TempLo;
        default: ;
      endcase
      program_regs(lim, on, off, hold);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     <= 0;
        end
        1: begin
          send_idle_pct = 67;
          stall_pct     <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     <= 67;
        end
        default: begin
          send_idle_pct = 13;
          stall_pct     <= 13;
        end
      endcase
      repeat (80) send_tick(random_tick());
    end

    settle();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
